### src/uer_pkg.sv
// Package with the constants, types and helper functions of the echo ranger.
package uer_pkg;

    // Timer arithmetic width; 16 to 64 bits.
    localparam int TIME_WIDTH = 32;
    localparam int TIME_IN_W  = 32;
    localparam int ECHO_W     = 1;

    localparam int DIST_W     = 28;
    localparam int FACTOR_W   = 6;
    localparam int TEMP_W     = 8;

    localparam longint DIST_MAX     = 134217727;
    localparam int     FACTOR_RESET = 58;

    // Sound-speed factor: FACT_NUM / (FACT_SLOPE * T + FACT_BASE).
    localparam int FACT_NUM   = 20000000;
    localparam int FACT_SLOPE = 606;
    localparam int FACT_BASE  = 331300;

    // Shared divider: the dividend must hold a time difference and the quotient
    // must be comparable against the distance ceiling.
    localparam int DIV_NW  = (TIME_WIDTH > DIST_W) ? TIME_WIDTH : DIST_W;
    // Largest divisor is 606 * 255 + 331300 = 485830, which fits in 19 bits.
    localparam int DIV_DW  = 19;
    localparam int DIV_CNT_W = $clog2(DIV_NW);

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
    } t_div_rsp;

    // Keeps the low TIME_WIDTH bits of a timestamp, zero-extending if wider.
    function automatic logic [TIME_WIDTH-1:0] to_time(input logic [TIME_IN_W-1:0] x);
        logic [63:0] w;
        w = 64'(x);
        return w[TIME_WIDTH-1:0];
    endfunction

endpackage

### src/uer_if.sv
// Handshake channel interfaces for edge events, range results and configuration.
interface uer_in_if;
    logic                           valid;
    logic                           ready;
    logic [uer_pkg::ECHO_W-1:0]     echo_level;
    logic [uer_pkg::TIME_IN_W-1:0]  time_us;

    modport source (output valid, output echo_level, output time_us, input ready);
    modport sink   (input valid, input echo_level, input time_us, output ready);
endinterface

interface uer_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [uer_pkg::DIST_W-1:0]  distance_cm;
    logic                               updated;

    modport source (output valid, output distance_cm, output updated, input ready);
    modport sink   (input valid, input distance_cm, input updated, output ready);
endinterface

interface uer_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [uer_pkg::TEMP_W-1:0]    temperature_c;

    modport source (output valid, output temperature_c, input ready);
    modport sink   (input valid, input temperature_c, output ready);
endinterface

### src/uer_div.sv
// Bit-serial restoring divider shared by range and sound-speed factor computation.
module uer_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  uer_pkg::t_div_req i_req,
    output uer_pkg::t_div_rsp o_rsp
);

    logic [uer_pkg::DIV_NW-1:0]    r_num;
    logic [uer_pkg::DIV_DW-1:0]    r_den;
    logic [uer_pkg::DIV_DW-1:0]    r_rem;
    logic [uer_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [uer_pkg::DIV_DW:0]      trial;
    logic                          fits;

    // The remainder stays below the divisor, so one extra bit holds the trial value.
    assign trial = {r_rem, r_num[uer_pkg::DIV_NW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_cnt  <= uer_pkg::DIV_CNT_W'(uer_pkg::DIV_NW - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? uer_pkg::DIV_DW'(trial - {1'b0, r_den})
                              : trial[uer_pkg::DIV_DW-1:0];
                r_num <= {r_num[uer_pkg::DIV_NW-2:0], fits};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

### src/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: sequencer, state and result register.
//
// Each transaction on the event channel is one edge of the echo line. A rising
// edge (echo_level 1) stores its timestamp as the pulse start and its result,
// with updated 0 and the held distance unchanged, is in the result register on
// the next cycle. A falling edge takes the timestamp difference modulo
// 2^TIME_WIDTH, divides it by the sound-speed factor in microseconds per
// centimeter, and loads its result (updated 1, new distance) into the result
// register once the divider is done; the event channel is not ready meanwhile.
// The single bit-serial divider retires one quotient bit per cycle. A
// temperature write recomputes the factor on the same divider as
// floor(20000000 / (606 * T + 331300)), and neither channel is ready meanwhile.
// After reset the factor is 58 (22 degrees Celsius) and the held distance is
// -1. A new event is taken while the previous result is being handed off, but
// not while it is still stalled.
module ultrasonic_echo_ranger (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uer_in_if.sink    i_evt,
    uer_out_if.source o_res,
    uer_cfg_if.sink   i_cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MEAS,
        S_FACT
    } t_state_e;

    t_state_e                              r_state;
    logic [uer_pkg::TIME_WIDTH-1:0]        r_pulse_start;
    logic signed [uer_pkg::DIST_W-1:0]     r_held;
    logic [uer_pkg::FACTOR_W-1:0]          r_factor;
    logic                                  r_out_valid;
    logic                                  r_out_updated;

    logic                                  in_ready;
    logic                                  cfg_ready;
    logic                                  in_acc;
    logic                                  cfg_acc;
    logic                                  res_load;
    logic [uer_pkg::TIME_WIDTH-1:0]        evt_time;
    logic [uer_pkg::TIME_WIDTH-1:0]        delta;
    logic [uer_pkg::DIV_DW-1:0]            fact_den;
    logic [uer_pkg::DIST_W-1:0]            n_held;

    uer_pkg::t_div_req                     div_req;
    uer_pkg::t_div_rsp                     div_rsp;

    // A new event may enter only when the sequencer is idle, no temperature write
    // is offered and the result register is empty or being emptied this same cycle.
    assign in_ready  = (r_state == S_IDLE) && (!r_out_valid || o_res.ready) && !i_cfg.valid;
    assign cfg_ready = (r_state == S_IDLE);
    assign in_acc    = i_evt.valid && in_ready;
    assign cfg_acc   = i_cfg.valid && cfg_ready;

    // The result register is loaded by an accepted rising edge or by the end of
    // a range computation; otherwise it empties once the receiver takes it.
    assign res_load  = (in_acc && i_evt.echo_level[0])
                     || ((r_state == S_MEAS) && div_rsp.done);

    assign evt_time = uer_pkg::to_time(i_evt.time_us);
    // Wraps naturally modulo 2^TIME_WIDTH.
    assign delta    = evt_time - r_pulse_start;
    assign fact_den = uer_pkg::DIV_DW'(uer_pkg::FACT_BASE)
                    + uer_pkg::DIV_DW'(uer_pkg::FACT_SLOPE)
                    * uer_pkg::DIV_DW'(i_cfg.temperature_c);

    // The divider is started either for the range quotient of a falling edge
    // or for the sound-speed factor of a temperature write.
    always_comb begin
        div_req.start = cfg_acc || (in_acc && !i_evt.echo_level[0]);
        if (cfg_acc) begin
            div_req.num = uer_pkg::DIV_NW'(uer_pkg::FACT_NUM);
            div_req.den = fact_den;
        end else begin
            div_req.num = uer_pkg::DIV_NW'(delta);
            div_req.den = uer_pkg::DIV_DW'(r_factor);
        end
    end

    // Quotients beyond the positive range of the distance field saturate.
    assign n_held = (div_rsp.quot > uer_pkg::DIV_NW'(uer_pkg::DIST_MAX))
                  ? uer_pkg::DIST_W'(uer_pkg::DIST_MAX)
                  : div_rsp.quot[uer_pkg::DIST_W-1:0];

    uer_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pulse_start <= '0;
            r_held        <= '1;
            r_factor      <= uer_pkg::FACTOR_W'(uer_pkg::FACTOR_RESET);
            r_out_valid   <= 1'b0;
            r_out_updated <= 1'b0;
        end else begin
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cfg_acc) begin
                        r_state <= S_FACT;
                    end else if (in_acc) begin
                        if (i_evt.echo_level[0]) begin
                            r_pulse_start <= evt_time;
                            r_out_updated <= 1'b0;
                        end else begin
                            r_state <= S_MEAS;
                        end
                    end
                end
                S_MEAS: begin
                    if (div_rsp.done) begin
                        r_held        <= n_held;
                        r_out_updated <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                S_FACT: begin
                    if (div_rsp.done) begin
                        r_factor <= div_rsp.quot[uer_pkg::FACTOR_W-1:0];
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_evt.ready       = in_ready;
    assign i_cfg.ready       = cfg_ready;
    assign o_res.valid       = r_out_valid;
    assign o_res.distance_cm = r_held;
    assign o_res.updated     = r_out_updated;

endmodule

### src/uer_checker.sv
// Port-level checker for the echo ranger and the bind that attaches it.
module uer_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_evt_valid,
    input logic                              i_evt_ready,
    input logic [uer_pkg::ECHO_W-1:0]        i_evt_level,
    input logic                              i_res_valid,
    input logic                              i_res_ready,
    input logic signed [uer_pkg::DIST_W-1:0] i_res_distance,
    input logic                              i_res_updated
);

    // A stalled result transaction keeps its payload.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_distance) && $stable(i_res_updated))
        else $error("result payload changed while stalled");

    // A rising edge produces its result, without an update, on the next cycle.
    a_rise_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt_valid && i_evt_ready && i_evt_level[0] |=> i_res_valid && !i_res_updated)
        else $error("rising edge did not yield an immediate non-update result");

    // A falling edge occupies the divider, so no new event is taken next cycle.
    a_fall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt_valid && i_evt_ready && !i_evt_level[0] |=> !i_evt_ready)
        else $error("event accepted while a range computation is running");

    // No event enters while a result is stalled at the output.
    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |-> !i_evt_ready)
        else $error("event channel ready while result is stalled");

    // A fresh measurement is never negative.
    a_upd_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_updated |-> !i_res_distance[uer_pkg::DIST_W-1])
        else $error("updated distance is negative");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_evt_valid    (i_evt.valid),
    .i_evt_ready    (i_evt.ready),
    .i_evt_level    (i_evt.echo_level),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_distance (o_res.distance_cm),
    .i_res_updated  (o_res.updated)
);
